[src/crdg_pkg.sv]
`timescale 1ns / 1ps

package crdg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TAN_BITS       = 20;
  localparam int TAN_FRAC       = 16;
  localparam int NORM_BITS      = 30;
  localparam int ROOT_BITS      = NORM_BITS + 1;
  localparam int SUM_BITS       = 2 * NORM_BITS + 2;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_TAN    = 2'd2
  } cfg_reg_t;

  // normalized magnitudes and signs of the unscaled direction
  typedef struct packed {
    logic [NORM_BITS-1:0] a;
    logic [NORM_BITS-1:0] b;
    logic [NORM_BITS-1:0] c;
    logic                 na;
    logic                 nb;
  } vec_t;

endpackage

[src/crdg_front.sv]
`timescale 1ns / 1ps

module crdg_front import crdg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] col,
  input  logic [COORD_BITS-1:0] row,
  input  logic [COORD_BITS:0]   width,
  input  logic [COORD_BITS:0]   height,
  input  logic [TAN_BITS-1:0]   tan,
  output logic                  out_valid,
  output vec_t                  out_vec,
  output logic [SUM_BITS-1:0]   out_sum
);

  localparam int DW  = COORD_BITS + 3;
  localparam int DM  = COORD_BITS + 2;
  localparam int MW  = DM + TAN_BITS;
  localparam int EW  = (MW > NORM_BITS) ? MW : NORM_BITS;
  localparam int SHW = $clog2(EW + 1);
  localparam int PW  = 2 * NORM_BITS;

  // stage 1: pixel offsets from the raster center, doubled
  logic [DW-1:0] dx, dy;
  logic [DM-1:0] dxm1, dym1;
  logic          na1, nb1, v1;
  logic [COORD_BITS:0] h1;

  assign dx = {2'b00, col, 1'b1} - {2'b00, width};
  assign dy = {2'b00, height} - {2'b00, row, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na1  <= dx[DW-1];
      nb1  <= dy[DW-1];
      dxm1 <= dx[DW-1] ? DM'(-dx) : dx[DM-1:0];
      dym1 <= dy[DW-1] ? DM'(-dy) : dy[DM-1:0];
      h1   <= height;
    end
  end

  // stage 2: scale by the tangent
  logic [MW-1:0] prod_a, prod_b;
  logic [MW-1:0] am2, bm2, cm2;
  logic          na2, nb2, v2;

  assign prod_a = {{TAN_BITS{1'b0}}, dxm1} * {{DM{1'b0}}, tan};
  assign prod_b = {{TAN_BITS{1'b0}}, dym1} * {{DM{1'b0}}, tan};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am2 <= prod_a;
      bm2 <= prod_b;
      cm2 <= MW'({h1, {TAN_FRAC{1'b0}}});
      na2 <= na1;
      nb2 <= nb1;
    end
  end

  // stage 3: bit length of the largest magnitude
  logic [MW-1:0]  orv;
  logic [SHW-1:0] blen, sh_amt;
  logic [MW-1:0]  am3, bm3, cm3;
  logic [SHW-1:0] sh3;
  logic           na3, nb3, v3;

  assign orv = am2 | bm2 | cm2;

  always_comb begin
    blen = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) blen = SHW'(i + 1);
    end
    sh_amt = (blen > SHW'(NORM_BITS)) ? SHW'(blen - SHW'(NORM_BITS)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am3 <= am2;
      bm3 <= bm2;
      cm3 <= cm2;
      sh3 <= sh_amt;
      na3 <= na2;
      nb3 <= nb2;
    end
  end

  // stage 4: truncate to the working width
  logic [EW-1:0] ae, be, ce;
  vec_t          vec4;
  logic          v4;

  assign ae = EW'(am3) >> sh3;
  assign be = EW'(bm3) >> sh3;
  assign ce = EW'(cm3) >> sh3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec4.a  <= ae[NORM_BITS-1:0];
      vec4.b  <= be[NORM_BITS-1:0];
      vec4.c  <= ce[NORM_BITS-1:0];
      vec4.na <= na3;
      vec4.nb <= nb3;
    end
  end

  // stage 5: squares
  logic [PW-1:0] aa5, bb5, cc5;
  vec_t          vec5;
  logic          v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa5  <= {{NORM_BITS{1'b0}}, vec4.a} * {{NORM_BITS{1'b0}}, vec4.a};
      bb5  <= {{NORM_BITS{1'b0}}, vec4.b} * {{NORM_BITS{1'b0}}, vec4.b};
      cc5  <= {{NORM_BITS{1'b0}}, vec4.c} * {{NORM_BITS{1'b0}}, vec4.c};
      vec5 <= vec4;
    end
  end

  // stage 6: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sum <= SUM_BITS'(aa5) + SUM_BITS'(bb5) + SUM_BITS'(cc5);
      out_vec <= vec5;
    end
  end

endmodule

[src/crdg_sqrt.sv]
`timescale 1ns / 1ps

module crdg_sqrt import crdg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  vec_t                 in_vec,
  input  logic [SUM_BITS-1:0]  in_sum,
  output logic                 out_valid,
  output vec_t                 out_vec,
  output logic [ROOT_BITS-1:0] out_root
);

  localparam int K  = ROOT_BITS;
  localparam int RW = K + 2;

  logic                v_c    [K];
  vec_t                vec_c  [K];
  logic [RW-1:0]       rem_c  [K];
  logic [K-1:0]        root_c [K];
  logic [SUM_BITS-1:0] x_c    [K];

  logic                v_r    [K];
  vec_t                vec_r  [K];
  logic [RW-1:0]       rem_r  [K];
  logic [K-1:0]        root_r [K];
  logic [SUM_BITS-1:0] x_r    [K];

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < K; k++) begin : g_stage
    logic [RW+1:0] r2, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_c[k]    = in_valid;
      assign vec_c[k]  = in_vec;
      assign rem_c[k]  = '0;
      assign root_c[k] = '0;
      assign x_c[k]    = in_sum;
    end else begin : g_next
      assign v_c[k]    = v_r[k-1];
      assign vec_c[k]  = vec_r[k-1];
      assign rem_c[k]  = rem_r[k-1];
      assign root_c[k] = root_r[k-1];
      assign x_c[k]    = x_r[k-1];
    end

    assign r2    = {rem_c[k], x_c[k][SUM_BITS-1 -: 2]};
    assign trial = (RW + 2)'({root_c[k], 2'b01});
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec_r[k]  <= vec_c[k];
        rem_r[k]  <= ge ? RW'(r2 - trial) : RW'(r2);
        root_r[k] <= {root_c[k][K-2:0], ge};
        x_r[k]    <= x_c[k] << 2;
      end
    end
  end

  assign out_valid = v_r[K-1];
  assign out_vec   = vec_r[K-1];
  assign out_root  = root_r[K-1];

endmodule

[src/crdg_div.sv]
`timescale 1ns / 1ps

module crdg_div import crdg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  vec_t                 in_vec,
  input  logic [ROOT_BITS-1:0] in_len,
  output logic                 out_valid,
  output logic                 out_na,
  output logic                 out_nb,
  output logic                 out_zero,
  output logic [FRAC_BITS:0]   out_qx,
  output logic [FRAC_BITS:0]   out_qy,
  output logic [FRAC_BITS:0]   out_qz
);

  localparam int K  = ROOT_BITS;
  localparam int QB = FRAC_BITS + 1;
  localparam int NW = NORM_BITS + FRAC_BITS + 1;
  localparam int NL = 3;

  logic [NORM_BITS-1:0] mag_in [NL];
  logic [NW-1:0]        numer  [NL];

  assign mag_in[0] = in_vec.a;
  assign mag_in[1] = in_vec.b;
  assign mag_in[2] = in_vec.c;

  logic         v_c    [QB];
  logic         na_c   [QB];
  logic         nb_c   [QB];
  logic         zero_c [QB];
  logic [K-1:0] len_c  [QB];
  logic [K-1:0] rem_c  [QB][NL];
  logic [QB-1:0] low_c [QB][NL];

  logic         v_r    [QB];
  logic         na_r   [QB];
  logic         nb_r   [QB];
  logic         zero_r [QB];
  logic [K-1:0] len_r  [QB];
  logic [K-1:0] rem_r  [QB][NL];
  logic [QB-1:0] low_r [QB][NL];

  // numerator carries the half-divisor for round half up
  for (genvar j = 0; j < NL; j++) begin : g_numer
    assign numer[j] = {1'b0, mag_in[j], {FRAC_BITS{1'b0}}} + NW'(in_len >> 1);
  end

  // restoring division, one quotient bit per stage; quotient bits shift in
  // where the numerator bits shift out
  for (genvar k = 0; k < QB; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign v_c[k]    = in_valid;
      assign na_c[k]   = in_vec.na;
      assign nb_c[k]   = in_vec.nb;
      assign zero_c[k] = (in_len == '0);
      assign len_c[k]  = in_len;
      for (genvar j = 0; j < NL; j++) begin : g_lane_in
        assign rem_c[k][j] = K'(numer[j][NW-1:QB]);
        assign low_c[k][j] = numer[j][QB-1:0];
      end
    end else begin : g_next
      assign v_c[k]    = v_r[k-1];
      assign na_c[k]   = na_r[k-1];
      assign nb_c[k]   = nb_r[k-1];
      assign zero_c[k] = zero_r[k-1];
      assign len_c[k]  = len_r[k-1];
      for (genvar j = 0; j < NL; j++) begin : g_lane_in
        assign rem_c[k][j] = rem_r[k-1][j];
        assign low_c[k][j] = low_r[k-1][j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        na_r[k]   <= na_c[k];
        nb_r[k]   <= nb_c[k];
        zero_r[k] <= zero_c[k];
        len_r[k]  <= len_c[k];
      end
    end

    for (genvar j = 0; j < NL; j++) begin : g_lane
      logic [K:0] r2, dv;
      logic       ge;

      assign r2 = {rem_c[k][j], low_c[k][j][QB-1]};
      assign dv = {1'b0, len_c[k]};
      assign ge = (r2 >= dv);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][j] <= ge ? K'(r2 - dv) : K'(r2);
          low_r[k][j] <= {low_c[k][j][QB-2:0], ge};
        end
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_na    = na_r[QB-1];
  assign out_nb    = nb_r[QB-1];
  assign out_zero  = zero_r[QB-1];
  assign out_qx    = low_r[QB-1][0];
  assign out_qy    = low_r[QB-1][1];
  assign out_qz    = low_r[QB-1][2];

endmodule

[src/camera_ray_direction_gen_top.sv]
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------
// input    | in_valid / in_ready   | pixel_col, pixel_row
// output   | out_valid / out_ready | dir_x, dir_y, dir_z
// config   | cfg_we                | cfg_addr, cfg_wdata
//
// One pixel accepted per cycle while in_ready is high; the pipeline is 6 front
// stages, 31 square-root stages, FRAC_BITS+1 divider stages and the output
// register. rst is synchronous and resets only valid bits and the config
// registers (to their defaults). The whole pipeline holds only when its last stage
// is full and the output register holds an untaken result; bubbles keep
// moving while the output waits.

module camera_ray_direction_gen_top import crdg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [COORD_BITS-1:0]       pixel_col,
  input  logic [COORD_BITS-1:0]       pixel_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+1:0] dir_x,
  output logic signed [FRAC_BITS+1:0] dir_y,
  output logic signed [FRAC_BITS:0]   dir_z,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [((COORD_BITS + 1 > TAN_BITS) ? COORD_BITS + 1 : TAN_BITS)-1:0] cfg_wdata
);

  localparam int QB = FRAC_BITS + 1;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;
  localparam logic signed [FRAC_BITS+1:0] ONE_XY = (FRAC_BITS + 2)'(ONE_Q);
  localparam logic signed [FRAC_BITS:0]   ONE_Z  = (FRAC_BITS + 1)'(ONE_Q);

  logic [COORD_BITS:0] width_r, height_r;
  logic [TAN_BITS-1:0] tan_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= (COORD_BITS + 1)'(640);
      height_r <= (COORD_BITS + 1)'(480);
      tan_r    <= TAN_BITS'(65536);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wdata[COORD_BITS:0];
        REG_HEIGHT: height_r <= cfg_wdata[COORD_BITS:0];
        REG_TAN:    tan_r    <= cfg_wdata[TAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic front_valid, sqrt_valid, div_valid;
  vec_t front_vec, sqrt_vec;
  logic [SUM_BITS-1:0]  front_sum;
  logic [ROOT_BITS-1:0] sqrt_root;
  logic div_na, div_nb, div_zero;
  logic [QB-1:0] qx, qy, qz;

  assign en       = !div_valid || !out_valid || out_ready;
  assign in_ready = en;

  crdg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .col       (pixel_col),
    .row       (pixel_row),
    .width     (width_r),
    .height    (height_r),
    .tan       (tan_r),
    .out_valid (front_valid),
    .out_vec   (front_vec),
    .out_sum   (front_sum)
  );

  crdg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_vec    (front_vec),
    .in_sum    (front_sum),
    .out_valid (sqrt_valid),
    .out_vec   (sqrt_vec),
    .out_root  (sqrt_root)
  );

  crdg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .in_vec    (sqrt_vec),
    .in_len    (sqrt_root),
    .out_valid (div_valid),
    .out_na    (div_na),
    .out_nb    (div_nb),
    .out_zero  (div_zero),
    .out_qx    (qx),
    .out_qy    (qy),
    .out_qz    (qz)
  );

  // clamp, zero-length case, signs
  logic [QB-1:0] mx, my, mz;

  always_comb begin
    if (div_zero) begin
      mx = '0;
      my = '0;
      mz = ONE_Q;
    end else begin
      mx = (qx > ONE_Q) ? ONE_Q : qx;
      my = (qy > ONE_Q) ? ONE_Q : qy;
      mz = (qz > ONE_Q) ? ONE_Q : qz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && div_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && div_valid) begin
      dir_x <= div_na ? -(FRAC_BITS + 2)'(mx) : (FRAC_BITS + 2)'(mx);
      dir_y <= div_nb ? -(FRAC_BITS + 2)'(my) : (FRAC_BITS + 2)'(my);
      dir_z <= -(FRAC_BITS + 1)'(mz);
    end
  end

  a_xy_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dir_x <= ONE_XY) && (dir_x >= -ONE_XY) &&
                  (dir_y <= ONE_XY) && (dir_y >= -ONE_XY))
    else $error("dir_x/dir_y outside unit range");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dir_z <= 0) && (dir_z >= -ONE_Z))
    else $error("dir_z outside [-1, 0]");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(div_valid))
    else $error("output loaded without a valid pipeline result");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import crdg_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int WD = (CB + 1 > TAN_BITS) ? CB + 1 : TAN_BITS;
  localparam int LATENCY = FB + 39;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [CB-1:0] pixel_col = '0;
  logic [CB-1:0] pixel_row = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [FB+1:0] dir_x;
  logic signed [FB+1:0] dir_y;
  logic signed [FB:0] dir_z;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [WD-1:0] cfg_wdata = '0;

  typedef struct {
    logic signed [FB+1:0] x;
    logic signed [FB+1:0] y;
    logic signed [FB:0]   z;
  } ray_dir_t;

  ray_dir_t dir_queue[$];
  int errors = 0;
  int burst_left = 0;

  // shadow copies of the configuration
  logic [CB:0] width_q = 640;
  logic [CB:0] height_q = 480;
  logic [TAN_BITS-1:0] tan_q = 65536;

  camera_ray_direction_gen_top dut (.*);

  always #1 clk = ~clk;

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] unit_mag(logic [63:0] v, logic [63:0] len);
    logic [63:0] q;
    q = ((v << FB) + (len >> 1)) / len;
    return (q > (64'd1 << FB)) ? (64'd1 << FB) : q;
  endfunction

  function automatic ray_dir_t ray_direction(logic [CB-1:0] col, logic [CB-1:0] row);
    longint sa, sb;
    logic [63:0] a, b, c, m, len, mx, my, mz;
    int n;
    ray_dir_t r;
    sa = (2 * longint'(col) + 1 - longint'(width_q)) * longint'(tan_q);
    sb = (longint'(height_q) - 2 * longint'(row) - 1) * longint'(tan_q);
    a = (sa < 0) ? -sa : sa;
    b = (sb < 0) ? -sb : sb;
    c = 64'(height_q) << TAN_FRAC;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    n = 0;
    while (m != 0) begin
      m >>= 1;
      n++;
    end
    if (n > NORM_BITS) begin
      a >>= (n - NORM_BITS);
      b >>= (n - NORM_BITS);
      c >>= (n - NORM_BITS);
    end
    len = isqrt64(a * a + b * b + c * c);
    if (len == 0) begin
      mx = 0;
      my = 0;
      mz = 64'd1 << FB;
    end else begin
      mx = unit_mag(a, len);
      my = unit_mag(b, len);
      mz = unit_mag(c, len);
    end
    r.x = (sa < 0) ? -mx[FB+1:0] : mx[FB+1:0];
    r.y = (sb < 0) ? -my[FB+1:0] : my[FB+1:0];
    r.z = -mz[FB:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // sender sometimes idles between bursts of random length; valid stays up inside a burst
  task automatic send_pixel(logic [CB-1:0] col, logic [CB-1:0] row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    dir_queue.push_back(ray_direction(col, row));
    in_valid <= 1;
    pixel_col <= col;
    pixel_row <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    ray_dir_t e;
    if (!rst && out_valid && out_ready) begin
      if (dir_queue.size() == 0) begin
        $display("unexpected transfer: %0d %0d %0d", dir_x, dir_y, dir_z);
        errors++;
      end else begin
        e = dir_queue.pop_front();
        if (dir_x !== e.x) report("dir_x", dir_x, e.x);
        if (dir_y !== e.y) report("dir_y", dir_y, e.y);
        if (dir_z !== e.z) report("dir_z", dir_z, e.z);
      end
    end
  end

  // receiver stall pattern: long ready stretches mixed with choppy ones
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9])
      out_ready <= 1;
    else
      out_ready <= ($urandom_range(0, 3) != 0) && !(stall_phase[5:2] == 4'hf);
  end

  task automatic drain;
    in_valid <= 0;
    while (dir_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [WD-1:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  width_q = val[CB:0];
      REG_HEIGHT: height_q = val[CB:0];
      REG_TAN:    tan_q = val[TAN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [CB:0] w, logic [CB:0] h, logic [TAN_BITS-1:0] t);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_TAN, t);
    cfg_we <= 0;
  endtask

  task automatic test_defaults;
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(320, 240);
    send_pixel(4095, 4095);   // outside raster
    send_pixel(0, 4095);
  endtask

  task automatic test_extremes;
    set_camera(4096, 4096, 20'hfffff);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2048, 0);
    set_camera(1, 1, 1);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
  endtask

  task automatic test_special;
    set_camera(100, 0, 65536);      // zero height: dir_z 0
    send_pixel(0, 0);
    send_pixel(99, 7);
    set_camera(100, 50, 0);         // zero tangent
    send_pixel(3, 4);
    set_camera(1, 0, 65536);        // x and z components zero
    send_pixel(0, 0);
    set_camera(8191, 8191, 20'h80000);  // full register width
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    drain();
    // unused index 3 must be ignored
    cfg_we <= 1;
    cfg_addr <= 2'd3;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_we <= 0;
    send_pixel(1, 1);
  endtask

  task automatic test_random;
    logic [CB:0] w, h;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
        1: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
        2: begin w = $urandom; h = $urandom; end
        default: begin w = 640; h = 480; end
      endcase
      set_camera(w, h, (p == 5) ? 20'hfffff : 20'($urandom));
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel($urandom, $urandom);
        else
          send_pixel($urandom_range(0, (w == 0 || w > 4096) ? 4095 : w - 1),
                     $urandom_range(0, (h == 0 || h > 4096) ? 4095 : h - 1));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_special();
    test_random();
    drain();
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
